@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/sbus_rx_pkg.sv @@
package sbus_rx_pkg;

	localparam int FRAME_LEN     = 25;
	localparam int CHANNEL_COUNT = 16;
	localparam int RAW_W         = 11;
	localparam int DATA_BYTES    = 22;
	localparam int FLAGS_POS     = 23;
	localparam int LOST_BIT      = 2;
	localparam int FS_BIT        = 3;

	localparam logic [4:0]  LAST_POS     = 5'd24;
	localparam logic [7:0]  HDR_BYTE     = 8'h0F;
	localparam logic [7:0]  END_BYTE     = 8'h00;
	localparam logic [3:0]  SBUS2_NIBBLE = 4'h4;
	localparam logic [15:0] GAP_RESET    = 16'd3000;
	localparam logic [11:0] PULSE_OFFSET = 12'd880;
	localparam logic signed [12:0] PULSE_MID = 13'sd1500;
	localparam logic signed [12:0] SCALE_LIM = 13'sd1000;

	typedef logic [4:0]  pos_t;
	typedef logic [3:0]  chan_t;
	typedef logic [10:0] raw_t;

endpackage

@@ rtl/sbus_rx_if.sv @@
interface sbus_rx_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [31:0] arrival_time_us;

	modport source (output valid, rx_byte, arrival_time_us, input ready);
	modport sink (input valid, rx_byte, arrival_time_us, output ready);
endinterface

interface sbus_rx_out_if;
	logic                valid;
	logic                ready;
	logic [4:0]          channel_index;
	sbus_rx_pkg::raw_t   raw_value;
	logic [11:0]         pulse_us;
	logic signed [10:0]  scaled_value;
	logic                frame_lost;
	logic                failsafe;
	logic [31:0]         frame_count;
	logic                last;

	modport source (output valid, channel_index, raw_value, pulse_us, scaled_value,
		frame_lost, failsafe, frame_count, last, input ready);
	modport sink (input valid, channel_index, raw_value, pulse_us, scaled_value,
		frame_lost, failsafe, frame_count, last, output ready);
endinterface

interface sbus_rx_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/sbus_frame_receiver.sv @@
// Input: one byte beat per cycle; stalls only when a frame's 25th byte arrives while
//   the previous frame's 16 result beats are still draining from the channel buffer.
// Path: the taken footer beat loads the channel buffer; the first result
//   beat is registered from it once the output register is free.
// Output: one result beat per cycle while result.ready is high, 16 per frame.
// Reset (arst_n low): frame position, last arrival time, frame count and result
//   valid cleared; gap threshold returns to 3000 us.
module sbus_frame_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	sbus_rx_cfg_if.sink          cfg,
	sbus_rx_in_if.sink           rx,
	sbus_rx_out_if.source        result
);

	logic [15:0]       gap_q;
	sbus_rx_pkg::pos_t pos_q;
	logic [31:0]       prev_q;
	logic [31:0]       frames_q;
	logic [7:0]        bytes_q [sbus_rx_pkg::FRAME_LEN];

	logic [8*sbus_rx_pkg::DATA_BYTES-1:0] data_q;
	logic                lost_q;
	logic                fs_q;
	logic [31:0]         count_q;
	logic                busy_q;
	sbus_rx_pkg::chan_t  ch_q;
	logic                out_valid_q;

	logic                rx_take;
	logic [31:0]         gap;
	logic                restart;
	sbus_rx_pkg::pos_t   pos_eff;
	logic                drop;
	logic                complete;
	logic                footer_ok;
	logic                load;
	logic                advance;
	sbus_rx_pkg::raw_t   ch_raw [sbus_rx_pkg::CHANNEL_COUNT];
	sbus_rx_pkg::raw_t   raw_sel;
	logic [13:0]         x5;
	logic [11:0]         pulse;
	logic signed [12:0]  diff2;
	logic signed [10:0]  scaled;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !(busy_q && (pos_q == sbus_rx_pkg::LAST_POS));
	assign rx_take   = rx.valid && rx.ready;

	always_comb begin
		gap       = rx.arrival_time_us - prev_q;
		restart   = gap > {16'd0, gap_q};
		pos_eff   = restart ? '0 : pos_q;
		drop      = (pos_eff == '0) && (rx.rx_byte != sbus_rx_pkg::HDR_BYTE);
		complete  = !drop && (pos_eff == sbus_rx_pkg::LAST_POS);
		footer_ok = (rx.rx_byte == sbus_rx_pkg::END_BYTE) ||
			(rx.rx_byte[3:0] == sbus_rx_pkg::SBUS2_NIBBLE);
		load      = rx_take && complete && footer_ok;
		advance   = busy_q && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= sbus_rx_pkg::GAP_RESET;
			pos_q    <= '0;
			prev_q   <= '0;
			frames_q <= '0;
		end else begin
			if (cfg.valid)
				gap_q <= cfg.data;
			if (rx_take) begin
				prev_q <= rx.arrival_time_us;
				if (drop || complete)
					pos_q <= '0;
				else
					pos_q <= pos_eff + 5'd1;
			end
			if (load)
				frames_q <= frames_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && !drop)
			bytes_q[pos_eff] <= rx.rx_byte;
	end

	// channel buffer, frees the byte store for the next frame
	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < sbus_rx_pkg::DATA_BYTES; j++)
				data_q[8*j +: 8] <= bytes_q[j+1];
			lost_q  <= bytes_q[sbus_rx_pkg::FLAGS_POS][sbus_rx_pkg::LOST_BIT];
			fs_q    <= bytes_q[sbus_rx_pkg::FLAGS_POS][sbus_rx_pkg::FS_BIT];
			count_q <= frames_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (advance) begin
				ch_q <= ch_q + 4'd1;
				if (ch_q == 4'(sbus_rx_pkg::CHANNEL_COUNT - 1))
					busy_q <= 1'b0;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < sbus_rx_pkg::CHANNEL_COUNT; i++)
			ch_raw[i] = data_q[i*sbus_rx_pkg::RAW_W +: sbus_rx_pkg::RAW_W];
		raw_sel = ch_raw[ch_q];
		x5      = {1'b0, raw_sel, 2'b00} + {3'b000, raw_sel};
		pulse   = {1'b0, x5[13:3]} + sbus_rx_pkg::PULSE_OFFSET;
		diff2   = (signed'({1'b0, pulse}) - sbus_rx_pkg::PULSE_MID) <<< 1;
		priority if (diff2 > sbus_rx_pkg::SCALE_LIM)
			scaled = 11'(sbus_rx_pkg::SCALE_LIM);
		else if (diff2 < -sbus_rx_pkg::SCALE_LIM)
			scaled = 11'(-sbus_rx_pkg::SCALE_LIM);
		else
			scaled = diff2[10:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.channel_index <= {1'b0, ch_q} + 5'd1;
			result.raw_value     <= raw_sel;
			result.pulse_us      <= pulse;
			result.scaled_value  <= scaled;
			result.frame_lost    <= lost_q;
			result.failsafe      <= fs_q;
			result.frame_count   <= count_q;
			result.last          <= ch_q == 4'(sbus_rx_pkg::CHANNEL_COUNT - 1);
		end
	end

	assign result.valid = out_valid_q;

endmodule

@@ rtl/sbus_rx_checker.sv @@
`include "assert_macros.svh"

module sbus_rx_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [4:0]         channel_index,
	input logic signed [10:0] scaled_value,
	input logic [31:0]        frame_count,
	input logic               last
);

	logic beat;

	assign beat = out_valid && out_ready;

	// stalled beat holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(channel_index))
	`ASSERT_IMPLY(a_last_ch, clk, arst_n, out_valid, last == (channel_index == 5'd16))
	`ASSERT_NEXT(a_burst_seq, clk, arst_n, beat && !last, out_valid && (channel_index == $past(channel_index) + 5'd1) && (frame_count == $past(frame_count)))
	`ASSERT_IMPLY(a_clamp, clk, arst_n, out_valid, (scaled_value <= 11'sd1000) && (scaled_value >= -11'sd1000))

endmodule

bind sbus_frame_receiver sbus_rx_checker u_sbus_rx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.channel_index (result.channel_index),
	.scaled_value  (result.scaled_value),
	.frame_count   (result.frame_count),
	.last          (result.last)
);

@@ dv/sbus_frame_receiver_tb.sv @@
`timescale 1ns / 100ps

module sbus_frame_receiver_tb;

	localparam int PERIOD = 12;

	typedef struct packed {
		logic [4:0]         chan;
		sbus_rx_pkg::raw_t  raw;
		logic [11:0]        pulse;
		logic signed [10:0] scaled;
		logic               lost;
		logic               fs;
		logic [31:0]        count;
		logic               last;
	} chan_beat_t;

	typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_HEADERS} fill_t;

	logic clk = 1'b0;
	logic arst_n;

	sbus_rx_in_if  rx_bus();
	sbus_rx_out_if res_bus();
	sbus_rx_cfg_if cfg_bus();

	sbus_frame_receiver DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.rx     (rx_bus),
		.result (res_bus)
	);

	// decoder state mirrored from the byte stream
	logic [15:0]       gap_limit = sbus_rx_pkg::GAP_RESET;
	sbus_rx_pkg::pos_t frame_pos = '0;
	logic [7:0]        frame_buf [sbus_rx_pkg::FRAME_LEN];
	logic [31:0]       last_arrival = '0;
	logic [31:0]       frames_seen = '0;

	chan_beat_t  pending_channels [$];
	logic [7:0]  frame_img [sbus_rx_pkg::FRAME_LEN];
	logic [31:0] now_us = '0;
	int          mismatches = 0;
	bit          calm = 1'b0;

	always #(PERIOD / 2) clk = ~clk;

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic take_byte(input logic [7:0] b, input logic [31:0] t);
		logic [31:0]  gap;
		logic [7:0]   footer;
		logic [7:0]   flags;
		logic [175:0] bits;
		chan_beat_t   e;
		int           pulse;
		int           sc;
		gap = t - last_arrival;
		if (gap > {16'd0, gap_limit})
			frame_pos = '0;
		last_arrival = t;
		if (frame_pos == 0 && b != sbus_rx_pkg::HDR_BYTE)
			return;
		frame_buf[frame_pos] = b;
		frame_pos++;
		if (frame_pos < sbus_rx_pkg::FRAME_LEN)
			return;
		frame_pos = '0;
		footer = frame_buf[sbus_rx_pkg::FRAME_LEN - 1];
		if (!(footer == sbus_rx_pkg::END_BYTE || footer[3:0] == sbus_rx_pkg::SBUS2_NIBBLE))
			return;
		frames_seen++;
		flags = frame_buf[sbus_rx_pkg::FLAGS_POS];
		for (int k = 0; k < sbus_rx_pkg::DATA_BYTES; k++)
			bits[8 * k +: 8] = frame_buf[1 + k];
		for (int ch = 0; ch < sbus_rx_pkg::CHANNEL_COUNT; ch++) begin
			e.chan   = 5'(ch + 1);
			e.raw    = bits[sbus_rx_pkg::RAW_W * ch +: sbus_rx_pkg::RAW_W];
			pulse    = int'(e.raw) * 5 / 8 + int'(sbus_rx_pkg::PULSE_OFFSET);
			sc       = (pulse - int'(sbus_rx_pkg::PULSE_MID)) * 2;
			if (sc > int'(sbus_rx_pkg::SCALE_LIM))
				sc = int'(sbus_rx_pkg::SCALE_LIM);
			if (sc < -int'(sbus_rx_pkg::SCALE_LIM))
				sc = -int'(sbus_rx_pkg::SCALE_LIM);
			e.pulse  = pulse[11:0];
			e.scaled = sc[10:0];
			e.lost   = flags[sbus_rx_pkg::LOST_BIT];
			e.fs     = flags[sbus_rx_pkg::FS_BIT];
			e.count  = frames_seen;
			e.last   = (ch == sbus_rx_pkg::CHANNEL_COUNT - 1);
			pending_channels.push_back(e);
		end
	endtask

	task automatic note_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk) begin : beat_check
		chan_beat_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_channels.size() == 0) begin
				note_mismatch("unexpected beat, channel_index", -1, res_bus.channel_index);
			end else begin
				want = pending_channels.pop_front();
				if (res_bus.channel_index !== want.chan)
					note_mismatch("channel_index", want.chan, res_bus.channel_index);
				if (res_bus.raw_value !== want.raw)
					note_mismatch("raw_value", want.raw, res_bus.raw_value);
				if (res_bus.pulse_us !== want.pulse)
					note_mismatch("pulse_us", want.pulse, res_bus.pulse_us);
				if (res_bus.scaled_value !== want.scaled)
					note_mismatch("scaled_value", want.scaled, res_bus.scaled_value);
				if (res_bus.frame_lost !== want.lost)
					note_mismatch("frame_lost", want.lost, res_bus.frame_lost);
				if (res_bus.failsafe !== want.fs)
					note_mismatch("failsafe", want.fs, res_bus.failsafe);
				if (res_bus.frame_count !== want.count)
					note_mismatch("frame_count", want.count, res_bus.frame_count);
				if (res_bus.last !== want.last)
					note_mismatch("last", want.last, res_bus.last);
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			res_bus.ready <= calm || ($urandom_range(99) >= 8);
	end

	// caller sits at a falling edge; returns at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic [31:0] gap);
		while (!calm && $urandom_range(99) < 8)
			@(negedge clk);
		now_us = now_us + gap;
		rx_bus.valid           = 1'b1;
		rx_bus.rx_byte         = b;
		rx_bus.arrival_time_us = now_us;
		@(posedge clk);
		while (!rx_bus.ready)
			@(posedge clk);
		take_byte(b, now_us);
		@(negedge clk);
		rx_bus.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_channels.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_gap(input logic [15:0] value);
		wait_drained();
		cfg_bus.valid = 1'b1;
		cfg_bus.data  = value;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		gap_limit = value;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	function automatic logic [31:0] restart_gap();
		return {16'd0, gap_limit} + 32'd1 + $urandom_range(500);
	endfunction

	task automatic build_frame(input fill_t fill, input logic [7:0] flags,
		input logic [7:0] footer);
		frame_img[0] = sbus_rx_pkg::HDR_BYTE;
		for (int i = 1; i <= sbus_rx_pkg::DATA_BYTES; i++) begin
			case (fill)
				FILL_ZERO:    frame_img[i] = 8'h00;
				FILL_ONES:    frame_img[i] = 8'hFF;
				FILL_HEADERS: frame_img[i] = sbus_rx_pkg::HDR_BYTE;
				default:      frame_img[i] = 8'($urandom);
			endcase
		end
		frame_img[sbus_rx_pkg::FLAGS_POS]     = flags;
		frame_img[sbus_rx_pkg::FRAME_LEN - 1] = footer;
	endtask

	// byte 0 waits lead_gap, byte edge_idx exactly edge_gap, others up to max_gap
	task automatic send_frame(input logic [31:0] lead_gap, input logic [31:0] max_gap,
		input int edge_idx, input logic [31:0] edge_gap, input int nbytes);
		logic [31:0] gap;
		for (int i = 0; i < nbytes; i++) begin
			if (i == 0)
				gap = lead_gap;
			else if (i == edge_idx)
				gap = edge_gap;
			else
				gap = $urandom_range(max_gap);
			send_byte(frame_img[i], gap);
		end
	endtask

	task automatic test_directed_frames();
		// all channels clamp high; SBUS2 footer
		build_frame(FILL_ONES, 8'h0C, {4'hA, sbus_rx_pkg::SBUS2_NIBBLE});
		send_frame(restart_gap(), 32'd100, sbus_rx_pkg::FRAME_LEN, 32'd0,
			sbus_rx_pkg::FRAME_LEN);
	endtask

	task automatic test_gap_restart();
		build_frame(FILL_HEADERS, 8'h00, sbus_rx_pkg::END_BYTE);
		send_frame(32'd10, 32'd50, sbus_rx_pkg::FRAME_LEN, 32'd0, 2);
		// one over the limit restarts; exactly the limit holds
		build_frame(FILL_RANDOM, 8'($urandom), sbus_rx_pkg::END_BYTE);
		send_frame({16'd0, gap_limit} + 32'd1, {16'd0, gap_limit}, 12, {16'd0, gap_limit},
			sbus_rx_pkg::FRAME_LEN);
	endtask

	task automatic test_timestamp_wrap();
		now_us = 32'hFFFF_FFC0;
		// timestamp steps back by one: the wrapped gap is huge; byte 2 crosses the wrap
		build_frame(FILL_RANDOM, 8'($urandom), sbus_rx_pkg::END_BYTE);
		send_frame(32'hFFFF_FFFF, 32'd40, 2, 32'd100, sbus_rx_pkg::FRAME_LEN);
	endtask

	task automatic test_threshold_extremes();
		write_gap(16'd0);
		build_frame(FILL_ZERO, 8'h00, sbus_rx_pkg::END_BYTE);
		send_frame(32'd5, 32'd0, 2, 32'd1, 4);
		write_gap(sbus_rx_pkg::GAP_RESET);
	endtask

	task automatic test_rejected_footer();
		build_frame(FILL_RANDOM, 8'($urandom), 8'hF1);
		send_frame(32'd3, 32'd20, sbus_rx_pkg::FRAME_LEN, 32'd0, sbus_rx_pkg::FRAME_LEN);
	endtask

	task automatic test_back_to_back();
		calm = 1'b1;
		build_frame(FILL_RANDOM, 8'($urandom), sbus_rx_pkg::END_BYTE);
		send_frame(32'($urandom_range(10)), 32'd20, sbus_rx_pkg::FRAME_LEN, 32'd0,
			sbus_rx_pkg::FRAME_LEN);
		calm = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n                 = 1'b0;
		rx_bus.valid           = 1'b0;
		rx_bus.rx_byte         = '0;
		rx_bus.arrival_time_us = '0;
		res_bus.ready          = 1'b0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.data           = '0;
		for (int i = 0; i < sbus_rx_pkg::FRAME_LEN; i++)
			frame_buf[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();
		test_gap_restart();
		test_timestamp_wrap();
		test_threshold_extremes();
		test_rejected_footer();
		test_back_to_back();

		while (pending_channels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_channels.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
